// ===== hw/rtl/sdtm_pkg.sv =====
// Package: shared types and constants of the stick deadzone trim mixer.
package sdtm_pkg;

    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CYCLE_MS      = 3'd0,
        REG_LEFT_DZ       = 3'd1,
        REG_RIGHT_DZ      = 3'd2,
        REG_THR_UP_STEP   = 3'd3,
        REG_THR_DOWN_STEP = 3'd4,
        REG_SURF_STEP     = 3'd5,
        REG_RUMBLE_HOLD   = 3'd6
    } reg_idx_t;

    localparam logic [15:0] BTN_THR_UP    = 16'd1;
    localparam logic [15:0] BTN_THR_DOWN  = 16'd2;
    localparam logic [15:0] BTN_THR_CLR   = 16'd4;
    localparam logic [15:0] BTN_SURF_CLR  = 16'd8;
    localparam logic [15:0] BTN_ALL_CLR   = 16'd768;
    localparam logic [15:0] BTN_AVG_UP    = 16'd4096;
    localparam logic [15:0] BTN_DIFF_UP   = 16'd8192;
    localparam logic [15:0] BTN_DIFF_DOWN = 16'd16384;
    localparam logic [15:0] BTN_AVG_DOWN  = 16'd32768;

    localparam logic [15:0] LEFT_SPEED  = 16'd15000;
    localparam logic [15:0] RIGHT_SPEED = 16'd25000;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ   = 6'b000010,
        ST_ROOT = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MIX  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

// ===== hw/rtl/stick_deadzone_trim_mixer_unit.sv =====
// Top level: stick deadzone, trim and elevon mixer with rumble feedback.
//
// One input beat (four stick axes and the button word) gives one output beat
// (throttle, two elevons, two rumble speeds). Items are handled one at a time.
// Per beat the sequencer:
//   - squares and sums each stick's axes with a 2-bit-per-cycle serial
//     multiplier,
//   - takes the integer root 2 bits per cycle,
//   - divides each of the three used axes with a 1-bit-per-cycle restoring
//     divider (load, numerator width steps, write),
//   - then applies the trim buttons, mixes, clamps and registers the result.
// A new beat can be taken from the cycle after the result is taken. The serial
// multiplier, root and divider units are single units shared by all axes.
// in_stall is high while an item is in work or a result waits. The result is
// held in output registers until out_stall is low. Reset clears trims, rumble
// state and configuration to their defaults; no item is in flight after it.
module stick_deadzone_trim_mixer_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [sdtm_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sdtm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] left_x,
    input  logic signed [15:0] left_y,
    input  logic signed [15:0] right_x,
    input  logic signed [15:0] right_y,
    input  logic [15:0] buttons,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] throttle,
    output logic signed [15:0] left_flap,
    output logic signed [15:0] right_flap,
    output logic [15:0] left_motor_speed,
    output logic [15:0] right_motor_speed
);
    import sdtm_pkg::*;

    // quotient bound: 32768*46340<<F / 1 fits in F+31 bits
    localparam int QW  = FRAC_BITS + 32;
    localparam int NW  = FRAC_BITS + 31;   // numerator width
    localparam int DW  = 32;               // denominator width
    localparam int TW  = FRAC_BITS + 2;    // trim width
    localparam int SW  = QW + 2;           // wide signed sum
    localparam logic signed [SW-1:0] ONE_W = SW'(1) <<< FRAC_BITS;
    localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< FRAC_BITS;
    localparam logic signed [TW-1:0] HALF_T = TW'(1) <<< (FRAC_BITS-1);
    localparam logic signed [TW+4:0] SEVEN_T = (TW+5)'(7) <<< FRAC_BITS;

    // configuration
    logic [9:0]  cycle_ms_reg;
    logic [14:0] left_dz_reg, right_dz_reg;
    logic [10:0] thr_up_reg, thr_down_reg, surf_step_reg;
    logic [13:0] hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_ms_reg  <= 10'd25;
            left_dz_reg   <= 15'd8349;
            right_dz_reg  <= 15'd9189;
            thr_up_reg    <= 11'd205;
            thr_down_reg  <= 11'd287;
            surf_step_reg <= 11'd29;
            hold_reg      <= 14'd500;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CYCLE_MS:      cycle_ms_reg  <= cfg_data[9:0];
                REG_LEFT_DZ:       left_dz_reg   <= cfg_data[14:0];
                REG_RIGHT_DZ:      right_dz_reg  <= cfg_data[14:0];
                REG_THR_UP_STEP:   thr_up_reg    <= cfg_data[10:0];
                REG_THR_DOWN_STEP: thr_down_reg  <= cfg_data[10:0];
                REG_SURF_STEP:     surf_step_reg <= cfg_data[10:0];
                REG_RUMBLE_HOLD:   hold_reg      <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // captured sample (payload)
    logic signed [15:0] ax_reg [4];
    logic [15:0] btn_reg;

    state_t state_reg;
    logic [1:0] sub_reg;        // SQ: axis 0..3; ROOT: stick; DIV: axis job
    logic [5:0] cnt_reg;

    // serial square: |axis| times itself, 2 bits a cycle
    logic [15:0] mcand_reg, mplier_reg;
    logic [32:0] sq_reg [2];    // sum of squares per stick
    logic [31:0] prod_reg;

    // root unit
    logic [32:0] rem_reg;
    logic [16:0] root_reg;
    logic [16:0] mag_reg [2];
    logic inside_reg [2];

    // divider
    logic [NW-1:0] num_reg;
    logic [DW:0]   drem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg;
    logic [6:0]    dcnt_reg;
    logic signed [SW-1:0] res_reg [3];  // 0: left y, 1: right x, 2: right y

    // trims and rumble
    logic signed [TW-1:0] thr_trim_reg, diff_trim_reg, avg_trim_reg;
    logic signed [17:0]   rumble_reg;
    logic [15:0] lspd_reg, rspd_reg;

    logic signed [15:0] thr_o_reg, lf_o_reg, rf_o_reg;
    logic out_valid_reg;

    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign throttle = thr_o_reg;
    assign left_flap = lf_o_reg;
    assign right_flap = rf_o_reg;
    assign left_motor_speed = lspd_reg;
    assign right_motor_speed = rspd_reg;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? 16'((-e)) : 16'(e);
    endfunction

    // divider job setup: axis selection
    logic signed [15:0] job_ax;
    logic [16:0] job_mag;
    logic [14:0] job_dz;
    always_comb
    begin
        case (sub_reg)
            2'd0:    begin job_ax = ax_reg[1]; job_mag = mag_reg[0]; job_dz = left_dz_reg; end
            2'd1:    begin job_ax = ax_reg[2]; job_mag = mag_reg[1]; job_dz = right_dz_reg; end
            default: begin job_ax = ax_reg[3]; job_mag = mag_reg[1]; job_dz = right_dz_reg; end
        endcase
    end

    // root step (2 bits per cycle, digit by digit)
    logic [34:0] trial;
    logic [32:0] rem_sh;
    logic [5:0]  rbit;
    always_comb
    begin
        rbit = 6'(30) - {cnt_reg[4:0], 1'b0};
        rem_sh = {rem_reg[30:0], 2'b00} |
                 33'((sq_reg[sub_reg[0]] >> rbit) & 33'd3);
        trial = {2'b00, rem_sh} - {16'd0, root_reg, 2'b01};
    end

    // divider step
    logic [DW:0] dsh;
    assign dsh = {drem_reg[DW-1:0], num_reg[NW-1]};

    // button handling and mix, applied at the end
    logic signed [TW-1:0] thr_n, diff_n, avg_n;
    logic signed [17:0] rum_n;
    logic [15:0] ls_n, rs_n;
    logic signed [SW-1:0] lf_w, rf_w, thr_w;
    logic signed [TW+4:0] avg10;

    function automatic logic signed [15:0] clampq(input logic signed [SW-1:0] v);
        if (v > ONE_W) return 16'(ONE_W);
        if (v < -ONE_W) return 16'(-ONE_W);
        return 16'(v);
    endfunction

    always_comb
    begin
        logic start_l, start_r;
        logic signed [17:0] dur, t;
        thr_n = thr_trim_reg; diff_n = diff_trim_reg; avg_n = avg_trim_reg;
        rum_n = rumble_reg; ls_n = lspd_reg; rs_n = rspd_reg;
        start_l = 1'b0; start_r = 1'b0;
        dur = 18'(cycle_ms_reg);
        avg10 = (TW+5)'(avg_trim_reg) * (TW+5)'(10);
        case (btn_reg)
            BTN_THR_UP:    if (thr_trim_reg < ONE_T) begin
                               thr_n = thr_trim_reg + TW'(thr_up_reg); start_l = 1'b1; end
            BTN_THR_DOWN:  if (thr_trim_reg > -ONE_T) begin
                               thr_n = thr_trim_reg - TW'(thr_down_reg); start_l = 1'b1; end
            BTN_DIFF_DOWN: if (diff_trim_reg > -HALF_T) begin
                               diff_n = diff_trim_reg - TW'(surf_step_reg); start_r = 1'b1; end
            BTN_DIFF_UP:   if (diff_trim_reg < HALF_T) begin
                               diff_n = diff_trim_reg + TW'(surf_step_reg); start_r = 1'b1; end
            BTN_AVG_DOWN:  if (avg10 > -SEVEN_T) begin
                               avg_n = avg_trim_reg - TW'(surf_step_reg); start_r = 1'b1; end
            BTN_AVG_UP:    if (avg10 < SEVEN_T) begin
                               avg_n = avg_trim_reg + TW'(surf_step_reg); start_r = 1'b1; end
            BTN_THR_CLR:   begin thr_n = '0; start_l = 1'b1; dur = 18'(hold_reg); end
            BTN_SURF_CLR:  begin avg_n = '0; diff_n = '0; start_r = 1'b1;
                               dur = 18'(hold_reg); end
            BTN_ALL_CLR:   begin thr_n = '0; avg_n = '0; diff_n = '0; start_r = 1'b1;
                               dur = 18'(hold_reg); end
            default: ;
        endcase
        if (start_l) begin ls_n = LEFT_SPEED; rs_n = '0; rum_n = dur; end
        if (start_r) begin ls_n = '0; rs_n = RIGHT_SPEED; rum_n = dur; end
        t = rum_n - 18'(cycle_ms_reg);
        if (t < 0) begin t = -18'sd1; ls_n = '0; rs_n = '0; end
        rum_n = t;
        lf_w = -res_reg[2] + SW'(avg_n) - res_reg[1] - SW'(diff_n);
        rf_w = -res_reg[2] + SW'(avg_n) + res_reg[1] + SW'(diff_n);
        thr_w = res_reg[0] + SW'(thr_n);
    end

    // fixed divisor span
    logic [15:0] span;
    always_comb
    begin
        logic [16:0] s;
        s = (job_ax[15] ? 17'd32768 : 17'd32767) - 17'(job_dz);
        span = (s[16] || s == 17'd0) ? 16'd1 : s[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            thr_trim_reg <= '0; diff_trim_reg <= '0; avg_trim_reg <= '0;
            rumble_reg <= '0; lspd_reg <= '0; rspd_reg <= '0;
            sub_reg <= '0; cnt_reg <= '0; dcnt_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (in_valid && !in_stall)
                begin
                    ax_reg[0] <= left_x; ax_reg[1] <= left_y;
                    ax_reg[2] <= right_x; ax_reg[3] <= right_y;
                    btn_reg <= buttons;
                    sub_reg <= 2'd0; cnt_reg <= '0;
                    mcand_reg <= mag16(left_x); mplier_reg <= mag16(left_x);
                    prod_reg <= '0;
                    sq_reg[0] <= '0; sq_reg[1] <= '0;
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (cnt_reg == 6'd8)
                    begin
                        sq_reg[sub_reg[1]] <= sq_reg[sub_reg[1]] + 33'(prod_reg);
                        prod_reg <= '0;
                        cnt_reg <= '0;
                        if (sub_reg == 2'd3)
                        begin
                            sub_reg <= '0; rem_reg <= '0; root_reg <= '0;
                            state_reg <= ST_ROOT;
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 2'd1;
                            mcand_reg <= mag16(ax_reg[sub_reg + 2'd1]);
                            mplier_reg <= mag16(ax_reg[sub_reg + 2'd1]);
                        end
                    end
                    else
                    begin
                        // shift-add, two multiplier bits per cycle
                        prod_reg <= prod_reg
                            + (mplier_reg[0] ? (32'(mcand_reg) << {cnt_reg[3:0], 1'b0}) : 32'd0)
                            + (mplier_reg[1] ? (32'(mcand_reg) << {cnt_reg[3:0], 1'b1}) : 32'd0);
                        mplier_reg <= mplier_reg >> 2;
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_ROOT:
                begin
                    if (cnt_reg == 6'd16)
                    begin
                        mag_reg[sub_reg[0]] <= root_reg;
                        inside_reg[sub_reg[0]] <= sq_reg[sub_reg[0]] <
                            33'((sub_reg[0] ? 32'(right_dz_reg) : 32'(left_dz_reg)) *
                                (sub_reg[0] ? 32'(right_dz_reg) : 32'(left_dz_reg)));
                        cnt_reg <= '0; rem_reg <= '0; root_reg <= '0;
                        if (sub_reg[0])
                        begin
                            sub_reg <= '0; dcnt_reg <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                            sub_reg <= 2'd1;
                    end
                    else
                    begin
                        if (trial[34])
                        begin
                            rem_reg <= rem_sh;
                            root_reg <= {root_reg[15:0], 1'b0};
                        end
                        else
                        begin
                            rem_reg <= trial[32:0];
                            root_reg <= {root_reg[15:0], 1'b1};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_DIV:
                begin
                    if (dcnt_reg == '0)
                    begin
                        // load: num = |v|*(mag-dz) << F, den = mag*span
                        num_reg <= NW'(33'(mag16(job_ax)) * 33'(job_mag - 17'(job_dz)))
                                   << FRAC_BITS;
                        den_reg <= DW'(job_mag) * DW'(span);
                        drem_reg <= '0; quo_reg <= '0;
                        dcnt_reg <= 7'd1;
                    end
                    else
                    begin
                        if (dsh >= {1'b0, den_reg})
                        begin
                            drem_reg <= dsh - {1'b0, den_reg};
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= dsh;
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        num_reg <= num_reg << 1;
                        dcnt_reg <= (dcnt_reg == 7'(NW + 1)) ? 7'd0 : dcnt_reg + 7'd1;
                        if (dcnt_reg == 7'(NW + 1))
                        begin
                            logic signed [SW-1:0] q;
                            q = SW'(quo_reg);
                            if (inside_reg[sub_reg != 2'd0] || job_mag == '0)
                                q = '0;
                            res_reg[sub_reg] <= job_ax[15] ? -q : q;
                            if (sub_reg == 2'd2)
                                state_reg <= ST_MIX;
                            else
                                sub_reg <= sub_reg + 2'd1;
                        end
                    end
                end
                ST_MIX:
                begin
                    thr_trim_reg <= thr_n; diff_trim_reg <= diff_n; avg_trim_reg <= avg_n;
                    rumble_reg <= rum_n; lspd_reg <= ls_n; rspd_reg <= rs_n;
                    thr_o_reg <= clampq(thr_w);
                    lf_o_reg <= clampq(lf_w);
                    rf_o_reg <= clampq(rf_w);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/sdtm_checker.sv =====
// Checker: port-level properties of the mixer, bound to the top level.
module sdtm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic signed [15:0] throttle,
    input logic [15:0] left_motor_speed,
    input logic [15:0] right_motor_speed
);
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("accepted but not busy");
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open with result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(throttle)))
        else $error("stalled result changed");
    a_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_motor_speed == 16'd0 || right_motor_speed == 16'd0))
        else $error("both motors running");
endmodule

bind stick_deadzone_trim_mixer_unit sdtm_checker u_sdtm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .throttle(throttle),
    .left_motor_speed(left_motor_speed), .right_motor_speed(right_motor_speed)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the stick deadzone, trim and elevon mixer unit.
import sdtm_pkg::*;

typedef struct {
    logic signed [15:0] lx, ly, rx, ry;
    logic [15:0]        btn;
} stick_sample_t;

typedef struct {
    logic signed [15:0] thr, lflap, rflap;
    logic [15:0]        lmot, rmot;
} mix_result_t;

// Mixer scoreboard: shadow registers, trim and rumble state, expected beats.
class mixer_scoreboard;
    localparam int QBITS = 14;

    int unsigned cyc_ms, dz_left, dz_right, thr_up, thr_down, surf_step, hold_ms;
    int          thr_trim, diff_trim, avg_trim, rumble_ms;
    logic [15:0] lmot_held, rmot_held;
    mix_result_t expected_q[$];
    int          mismatches;

    function new();
        cyc_ms = 25; dz_left = 8349; dz_right = 9189;
        thr_up = 205; thr_down = 287; surf_step = 29; hold_ms = 500;
        thr_trim = 0; diff_trim = 0; avg_trim = 0; rumble_ms = 0;
        lmot_held = 0; rmot_held = 0;
        mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_CYCLE_MS:      cyc_ms = v[9:0];
            REG_LEFT_DZ:       dz_left = v[14:0];
            REG_RIGHT_DZ:      dz_right = v[14:0];
            REG_THR_UP_STEP:   thr_up = v[10:0];
            REG_THR_DOWN_STEP: thr_down = v[10:0];
            REG_SURF_STEP:     surf_step = v[10:0];
            REG_RUMBLE_HOLD:   hold_ms = v[13:0];
            default: ;
        endcase
    endfunction

    // floor(sqrt(n)), two bits per pass
    function longint unsigned int_root(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // one axis outside the deadzone: v/mag * (mag-dz)/(full-dz), truncated
    function longint scale_axis(longint v, longint unsigned mag, longint unsigned dz);
        longint          span;
        longint unsigned a, num, den;
        if (mag == 0) return 0;
        span = ((v >= 0) ? 32767 : 32768) - longint'(dz);
        if (span < 1) span = 1;
        a = (v < 0) ? -v : v;
        num = (a * (mag - dz)) << QBITS;
        den = mag * longint'(span);
        return (v < 0) ? -longint'(num / den) : longint'(num / den);
    endfunction

    function void shape_stick(longint x, longint y, longint unsigned dz,
                              output longint ox, output longint oy);
        longint unsigned sq, mag;
        sq = x * x + y * y;
        ox = 0;
        oy = 0;
        if (sq >= dz * dz) begin
            mag = int_root(sq);
            ox = scale_axis(x, mag, dz);
            oy = scale_axis(y, mag, dz);
        end
    endfunction

    function void start_rumble(bit on_left, int ms);
        lmot_held = on_left ? LEFT_SPEED : 16'd0;
        rmot_held = on_left ? 16'd0 : RIGHT_SPEED;
        rumble_ms = ms;
    endfunction

    function longint clamp_unit(longint v);
        longint one;
        one = longint'(1) << QBITS;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function void note_sample(stick_sample_t s);
        longint      one, half, seven, lx, ly, rx, ry, avg;
        int          t;
        mix_result_t r;
        one = longint'(1) << QBITS;
        half = longint'(1) << (QBITS - 1);
        seven = longint'(7) << QBITS;
        shape_stick(s.lx, s.ly, dz_left, lx, ly);
        shape_stick(s.rx, s.ry, dz_right, rx, ry);
        case (s.btn)
            BTN_THR_UP:
                if (thr_trim < one) begin
                    thr_trim += thr_up; start_rumble(1, cyc_ms);
                end
            BTN_THR_DOWN:
                if (thr_trim > -one) begin
                    thr_trim -= thr_down; start_rumble(1, cyc_ms);
                end
            BTN_DIFF_DOWN:
                if (diff_trim > -half) begin
                    diff_trim -= surf_step; start_rumble(0, cyc_ms);
                end
            BTN_DIFF_UP:
                if (diff_trim < half) begin
                    diff_trim += surf_step; start_rumble(0, cyc_ms);
                end
            BTN_AVG_DOWN:
                if (longint'(avg_trim) * 10 > -seven) begin
                    avg_trim -= surf_step; start_rumble(0, cyc_ms);
                end
            BTN_AVG_UP:
                if (longint'(avg_trim) * 10 < seven) begin
                    avg_trim += surf_step; start_rumble(0, cyc_ms);
                end
            BTN_THR_CLR:
            begin
                thr_trim = 0; start_rumble(1, hold_ms);
            end
            BTN_SURF_CLR:
            begin
                avg_trim = 0; diff_trim = 0; start_rumble(0, hold_ms);
            end
            BTN_ALL_CLR:
            begin
                // left rumble is overwritten by the right one
                thr_trim = 0; avg_trim = 0; diff_trim = 0;
                start_rumble(1, hold_ms);
                start_rumble(0, hold_ms);
            end
            default: ;
        endcase
        avg = -ry + avg_trim;
        r.lflap = 16'(clamp_unit(avg - rx - diff_trim));
        r.rflap = 16'(clamp_unit(avg + rx + diff_trim));
        r.thr = 16'(clamp_unit(ly + thr_trim));
        t = rumble_ms - int'(cyc_ms);
        if (t < 0) begin
            t = -1; lmot_held = 0; rmot_held = 0;
        end
        rumble_ms = t;
        r.lmot = lmot_held;
        r.rmot = rmot_held;
        expected_q.push_back(r);
    endfunction

    function void check_result(mix_result_t got);
        mix_result_t want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: output beat with nothing expected");
            return;
        end
        want = expected_q.pop_front();
        if (got.thr !== want.thr || got.lflap !== want.lflap || got.rflap !== want.rflap
            || got.lmot !== want.lmot || got.rmot !== want.rmot) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: exp thr %0d lf %0d rf %0d lm %0d rm %0d / got %0d %0d %0d %0d %0d",
                         want.thr, want.lflap, want.rflap, want.lmot, want.rmot,
                         got.thr, got.lflap, got.rflap, got.lmot, got.rmot);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 3000000;   // cycles; slowest run is well under half
    localparam int HOLD_OFF  = 800;       // long receiver stall, longer than an item takes

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0;
    logic [15:0]        buttons = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    logic signed [15:0] throttle, left_flap, right_flap;
    logic [15:0]        left_motor_speed, right_motor_speed;

    mixer_scoreboard mixer_sb = new();
    int  cycle_count = 0;
    bit  quiet_mode = 0;      // no idling on either side while set
    bit  hold_request = 0;    // asks the receiver for one long stall
    int  burst_left = 0;
    logic [15:0] burst_code;

    logic [15:0] trim_codes [9] = '{BTN_THR_UP, BTN_THR_DOWN, BTN_THR_CLR, BTN_SURF_CLR,
                                    BTN_ALL_CLR, BTN_AVG_UP, BTN_DIFF_UP, BTN_DIFF_DOWN,
                                    BTN_AVG_DOWN};

    stick_deadzone_trim_mixer_unit DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("stick_deadzone_trim_mixer_unit regression: fail");
            $finish;
        end
    end

    // Receiver: checks each beat taken at this edge, then picks the next stall.
    // Values read here are the ones present at the edge.
    int hold_count = 0;
    always @(posedge clk)
    begin
        mix_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.thr = throttle; got.lflap = left_flap; got.rflap = right_flap;
            got.lmot = left_motor_speed; got.rmot = right_motor_speed;
            mixer_sb.check_result(got);
        end
        if (hold_request && hold_count == 0) begin
            hold_request <= 0;
            hold_count <= HOLD_OFF;
            out_stall <= 1'b1;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            out_stall <= (hold_count > 1);
        end else begin
            out_stall <= !quiet_mode && ($urandom_range(99) < 23);
        end
    end

    // One beat: drive at the edge, hold until an edge with stall low.
    task automatic send_beat(stick_sample_t s);
        in_valid <= 1'b1;
        left_x <= s.lx; left_y <= s.ly; right_x <= s.rx; right_y <= s.ry;
        buttons <= s.btn;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        mixer_sb.note_sample(s);
        if (!quiet_mode) begin
            while ($urandom_range(99) < 23) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_axes(int lx, int ly, int rx, int ry, logic [15:0] btn);
        stick_sample_t s;
        s.lx = 16'(lx); s.ly = 16'(ly); s.rx = 16'(rx); s.ry = 16'(ry); s.btn = btn;
        send_beat(s);
    endtask

    // Pause the sender until every expected beat is back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mixer_sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write enable stays high across a burst; write_all drops it at the end
    task automatic write_reg(reg_idx_t idx, int unsigned v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_DATA_W-1:0];
        @(posedge clk);
        mixer_sb.set_reg(idx, v[CFG_DATA_W-1:0]);
    endtask

    task automatic write_all(int unsigned c, int unsigned dl, int unsigned dr, int unsigned up,
                             int unsigned dn, int unsigned st, int unsigned hold);
        write_reg(REG_CYCLE_MS, c);
        write_reg(REG_LEFT_DZ, dl);
        write_reg(REG_RIGHT_DZ, dr);
        write_reg(REG_THR_UP_STEP, up);
        write_reg(REG_THR_DOWN_STEP, dn);
        write_reg(REG_SURF_STEP, st);
        write_reg(REG_RUMBLE_HOLD, hold);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(4))
            0: return 16'(int'($urandom_range(2000)) - 1000);     // near center
            1: begin
                case ($urandom_range(3))
                    0: return -16'sd32768;
                    1: return -16'sd32767;
                    2: return 16'sd32767;
                    default: return 16'sd0;
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    // Mostly bursts of trim codes so trims reach their limits; some raw noise.
    function automatic logic [15:0] pick_buttons();
        if (burst_left == 0) begin
            if ($urandom_range(99) < 25) return 16'($urandom());
            burst_code = trim_codes[$urandom_range(8)];
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        return burst_code;
    endfunction

    task automatic random_beats(int count);
        stick_sample_t s;
        repeat (count) begin
            s.lx = pick_axis(); s.ly = pick_axis();
            s.rx = pick_axis(); s.ry = pick_axis();
            s.btn = ($urandom_range(9) == 0) ? 16'd0 : pick_buttons();
            send_beat(s);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats at reset settings
        send_axes(0, 0, 0, 0, 16'd0);
        send_axes(-32768, -32768, -32768, -32768, 16'd0);
        send_axes(32767, 32767, 32767, 32767, 16'hFFFF);
        send_axes(0, 8348, 0, 9188, 16'd0);            // just inside both deadzones
        send_axes(0, 8349, 9189, 0, 16'd0);            // exactly on the radius
        send_axes(5000, -20000, -12000, 30000, BTN_THR_UP);
        send_axes(100, 20000, 15000, -15000, BTN_THR_DOWN);
        send_axes(0, 0, 20000, 0, BTN_DIFF_DOWN);
        send_axes(0, 0, 0, -20000, BTN_DIFF_UP);
        send_axes(0, 0, 0, 0, BTN_AVG_DOWN);
        send_axes(0, 0, 0, 0, BTN_AVG_UP);
        send_axes(0, 32767, 0, 0, BTN_THR_CLR);
        send_axes(0, 0, 0, 0, BTN_SURF_CLR);
        send_axes(0, 0, 0, 0, BTN_ALL_CLR);
        send_axes(0, 0, 0, 0, 16'd3);                  // unknown code
        send_axes(0, 0, 0, 0, 16'd768 | 16'd1);        // codes match only whole
        drain();

        // zero deadzone: stick at center, near center and full deflection
        write_all(1, 0, 0, 0, 0, 0, 0);
        send_axes(0, 0, 0, 0, BTN_THR_UP);
        send_axes(1, -1, -1, 1, BTN_ALL_CLR);
        send_axes(-32768, 32767, 32767, -32768, 16'd0);
        drain();

        // deadzone of full scale: positive axis divisor clamps to one
        write_all(1000, 32767, 32767, 1024, 1024, 1024, 10000);
        send_axes(32767, 32767, 32767, 32767, BTN_THR_CLR);
        send_axes(-32768, -32768, -32768, 32767, BTN_AVG_UP);
        send_axes(0, 32767, 32767, 0, 16'd0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: write_all(25, 8349, 9189, 205, 287, 29, 500);
                1: write_all(1, 0, 0, 1, 1, 1, 0);
                2: write_all(1000, 32000, 32000, 1024, 1024, 1024, 10000);
                3, 4: write_all($urandom_range(1000, 1), $urandom_range(32000),
                                $urandom_range(32000), $urandom_range(1024),
                                $urandom_range(1024), $urandom_range(1024),
                                $urandom_range(10000));
                default: write_all($urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom(), $urandom());
            endcase
            quiet_mode = (phase == 2);
            if (phase == 3) hold_request = 1;
            if (phase == 4) begin
                random_beats(70);
                drain();
                random_beats(78);
            end else begin
                random_beats(148);
            end
            quiet_mode = 0;
            drain();
        end

        repeat (300) @(posedge clk);
        if (mixer_sb.mismatches == 0 && mixer_sb.expected_q.size() == 0)
            $display("stick_deadzone_trim_mixer_unit regression: pass");
        else
            $display("stick_deadzone_trim_mixer_unit regression: fail");
        $finish;
    end
endmodule
